[hw/rtl/edtc_pkg.sv]
// edtc_pkg: types, codes and field widths for the edge and target drive controller
// shared by edtc_decide and edge_and_target_drive_controller_top; no dependencies

package edtc_pkg;

   localparam int DIST_W = 16;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int IDX_W  = 3;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;

   // drive modes
   localparam logic [1:0] MODE_STOPPED  = 2'd0;
   localparam logic [1:0] MODE_LINE     = 2'd1;
   localparam logic [1:0] MODE_STRAIGHT = 2'd2;
   localparam logic [1:0] MODE_SCAN     = 2'd3;

   // motor commands
   localparam logic [1:0] CMD_BRAKE    = 2'd0;
   localparam logic [1:0] CMD_ACW      = 2'd1;
   localparam logic [1:0] CMD_STRAIGHT = 2'd2;

   // display codes
   localparam logic [1:0] DISP_STOPPED  = 2'd0;
   localparam logic [1:0] DISP_TURNING  = 2'd1;
   localparam logic [1:0] DISP_STRAIGHT = 2'd2;
   localparam logic [1:0] DISP_READJUST = 2'd3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_DEVIATION = 3'd0;
   localparam logic [IDX_W-1:0] REG_TARGET    = 3'd1;
   localparam logic [IDX_W-1:0] REG_NO_ECHO   = 3'd2;
   localparam logic [IDX_W-1:0] REG_BRAKE     = 3'd3;
   localparam logic [IDX_W-1:0] REG_READJUST  = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [DIST_W-1:0] dist_right;
      logic [DIST_W-1:0] dist_centre;
      logic [DIST_W-1:0] dist_left;
      logic              line_rear_right;
      logic              line_rear_left;
      logic              line_front_right;
      logic              line_front_centre;
      logic              line_front_left;
   } item_type;

   typedef struct packed {
      logic       frame_dropped;
      logic [1:0] drive_mode;
      logic [1:0] display_code;
      logic       display_valid;
      logic [1:0] motor_cmd;
      logic       motor_valid;
   } result_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TIME_W-1:0] readjust_start;
      logic [TIME_W-1:0] brake_end;
      logic              braking;
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] off_centre_margin;
      logic [CFG_W-1:0] target_threshold;
      logic [CFG_W-1:0] no_echo_code;
      logic [CFG_W-1:0] brake_time_ms;
      logic [CFG_W-1:0] max_readjust_ms;
   } cfg_type;

endpackage

[hw/rtl/edtc_decide.sv]
// edtc_decide: per-frame decision logic, result and next controller state
// depends on edtc_pkg

module edtc_decide (
   input  edtc_pkg::item_type   item,
   input  edtc_pkg::state_type  state,
   input  edtc_pkg::cfg_type    cfg,
   output edtc_pkg::result_type result,
   output edtc_pkg::state_type  state_next
);
   import edtc_pkg::*;

   logic [TIME_W-1:0] remain;
   logic [TIME_W-1:0] elapsed;
   logic              dropped;
   logic              front_line;
   logic              rear_line;
   logic              target_seen;
   logic              off_left;
   logic              off_right;
   logic              brake;
   logic              mv;
   logic              dv;
   logic [1:0]        mc;
   logic [1:0]        dcode;
   logic [DIST_W-1:0] diff_left;
   logic [DIST_W-1:0] diff_right;

   always_comb begin
      remain     = state.brake_end - item.now_ms;
      elapsed    = item.now_ms - state.readjust_start;
      dropped    = state.braking && (remain != '0)
                   && (remain <= {{(TIME_W-CFG_W){1'b0}}, cfg.brake_time_ms});
      front_line = item.line_front_left | item.line_front_centre | item.line_front_right;
      rear_line  = item.line_rear_left | item.line_rear_right;
      target_seen = (item.dist_centre != cfg.no_echo_code)
                    && (item.dist_centre <= cfg.target_threshold);
      diff_left  = item.dist_centre - item.dist_left;
      diff_right = item.dist_centre - item.dist_right;
      off_left   = (item.dist_left != cfg.no_echo_code) && (item.dist_left < item.dist_centre)
                   && (diff_left >= cfg.off_centre_margin);
      off_right  = (item.dist_right != cfg.no_echo_code)
                   && (item.dist_right < item.dist_centre)
                   && (diff_right >= cfg.off_centre_margin);

      state_next = state;
      brake      = 1'b0;
      mv         = 1'b0;
      dv         = 1'b0;
      mc         = CMD_BRAKE;
      dcode      = DISP_STOPPED;

      if (state.braking && !dropped) begin
         state_next.braking = 1'b0;
      end

      if (!dropped) begin
         if (front_line) begin
            if (state.mode != MODE_LINE && state.mode != MODE_STOPPED) begin
               brake           = 1'b1;
               dv              = 1'b1;
               dcode           = DISP_STOPPED;
               state_next.mode = MODE_STOPPED;
            end else if (state.mode != MODE_LINE) begin
               mv              = 1'b1;
               mc              = CMD_ACW;
               dv              = 1'b1;
               dcode           = DISP_TURNING;
               state_next.mode = MODE_LINE;
            end
         end else if (rear_line) begin
            if (state.mode != MODE_STOPPED) begin
               brake           = 1'b1;
               state_next.mode = MODE_STOPPED;
            end else begin
               mv              = 1'b1;
               mc              = CMD_STRAIGHT;
               dv              = 1'b1;
               dcode           = DISP_STRAIGHT;
               state_next.mode = MODE_STRAIGHT;
            end
         end else if (target_seen) begin
            if (state.mode == MODE_LINE) begin
               brake           = 1'b1;
               dv              = 1'b1;
               dcode           = DISP_STOPPED;
               state_next.mode = MODE_STOPPED;
            end else if (off_left || off_right) begin
               state_next.readjust_start = item.now_ms;
               if (state.mode != MODE_SCAN) begin
                  mv              = 1'b1;
                  mc              = CMD_ACW;
                  dv              = 1'b1;
                  dcode           = DISP_READJUST;
                  state_next.mode = MODE_SCAN;
               end
            end else begin
               mv              = 1'b1;
               mc              = CMD_STRAIGHT;
               dv              = 1'b1;
               dcode           = DISP_STRAIGHT;
               state_next.mode = MODE_STRAIGHT;
            end
         end else if (state.mode != MODE_SCAN
                      || elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.max_readjust_ms}) begin
            mv                        = 1'b1;
            mc                        = CMD_STRAIGHT;
            dv                        = 1'b1;
            dcode                     = DISP_STRAIGHT;
            state_next.mode           = MODE_STRAIGHT;
            state_next.readjust_start = '0;
         end

         if (brake) begin
            mv                   = 1'b1;
            mc                   = CMD_BRAKE;
            state_next.braking   = 1'b1;
            state_next.brake_end = item.now_ms
                                   + {{(TIME_W-CFG_W){1'b0}}, cfg.brake_time_ms};
         end
      end

      result.motor_valid   = mv;
      result.motor_cmd     = mv ? mc : CMD_BRAKE;
      result.display_valid = dv;
      result.display_code  = dv ? dcode : DISP_STOPPED;
      result.drive_mode    = state_next.mode;
      result.frame_dropped = dropped;
   end

endmodule

[hw/rtl/edge_and_target_drive_controller_top.sv]
// edge_and_target_drive_controller_top: frame input register, decision stage,
// result register and configuration registers; depends on edtc_pkg and edtc_decide
// flow: frame input register, then result register; rsp_tready low stalls both
// throughput: one frame per cycle unless stalled; the single decision stage updates state
// reset: synchronous, active high; clears state, stage valids and restores register defaults

module edge_and_target_drive_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: line_front_left, line_front_centre, line_front_right, line_rear_left,
   //        line_rear_right, dist_left[16], dist_centre[16], dist_right[16], now_ms[32], pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [edtc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tdata: motor_valid, motor_cmd[2], display_valid, display_code[2], drive_mode[2],
   //        frame_dropped, pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [edtc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [edtc_pkg::IDX_W-1:0]        csr_index,
   input  logic [edtc_pkg::CFG_W-1:0]        csr_data
);
   import edtc_pkg::*;

   localparam int ITEM_W   = $bits(item_type);
   localparam int RESULT_W = $bits(result_type);

   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result_ff, result_in;
   logic       result_valid_ff, result_valid_in;
   state_type  state_ff, state_in, state_calc;
   cfg_type    cfg_ff, cfg_in;
   result_type result_calc;
   logic       advance;
   logic       req_transfer;

   edtc_decide u_decide (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .result     (result_calc),
      .state_next (state_calc)
   );

   assign advance      = item_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready   = !item_valid_ff || advance;
   assign req_transfer = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;

   always_comb begin
      item_in         = req_transfer ? item_type'(req_tdata[ITEM_W-1:0]) : item_ff;
      item_valid_in   = req_transfer ? 1'b1 : (item_valid_ff && !advance);
      result_in       = advance ? result_calc : result_ff;
      result_valid_in = advance ? 1'b1 : (result_valid_ff && !rsp_tready);
      state_in        = advance ? state_calc : state_ff;
      cfg_in          = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DEVIATION: cfg_in.off_centre_margin   = csr_data;
            REG_TARGET:    cfg_in.target_threshold    = csr_data;
            REG_NO_ECHO:   cfg_in.no_echo_code        = csr_data;
            REG_BRAKE:     cfg_in.brake_time_ms       = csr_data;
            REG_READJUST:  cfg_in.max_readjust_ms     = csr_data;
            default:       cfg_in                     = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
         state_ff        <= '{mode: MODE_STOPPED, readjust_start: '0, brake_end: '0,
                              braking: 1'b0};
         cfg_ff          <= '{off_centre_margin: 16'd10, target_threshold: 16'd60,
                              no_echo_code: 16'hFFFF, brake_time_ms: 16'd100,
                              max_readjust_ms: 16'd1000};
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
         state_ff        <= state_in;
         cfg_ff          <= cfg_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RESULT_W){1'b0}}, result_ff};

endmodule
